### rtl/tpdf_pkg.sv
// ----------------------------------------------------------------------------
// TPDF dither package
// Shared constants, codes and control types of the TPDF dither block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpdf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED       = 1'b1;

  localparam int DEPTH_W = 2;
  localparam logic [DEPTH_W-1:0] DEPTH_OFF = 2'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_16  = 2'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_24  = 2'd2;

  localparam logic [63:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;

  localparam int MIX_SHIFT_0 = 30;
  localparam int MIX_SHIFT_1 = 27;
  localparam int MIX_SHIFT_2 = 31;

  localparam int MUL_W  = 32;
  localparam int DRAW_W = 53;
  localparam int MAG_W  = DRAW_W + 1;
  localparam int STEP_W = 33;
  localparam int ACC_W  = 88;
  localparam int OFF_W  = ACC_W - DRAW_W;

  localparam logic [63:0] STEP_SCALE = 64'd1 << 47;
  localparam logic [63:0] DIV_16     = 64'd32767;
  localparam logic [63:0] DIV_24     = 64'd8388607;
  localparam logic [63:0] STEP16_FULL = (STEP_SCALE + (DIV_16 >> 1)) / DIV_16;
  localparam logic [63:0] STEP24_FULL = (STEP_SCALE + (DIV_24 >> 1)) / DIV_24;
  localparam logic [STEP_W-1:0] STEP16 = STEP16_FULL[STEP_W-1:0];
  localparam logic [STEP_W-1:0] STEP24 = STEP24_FULL[STEP_W-1:0];

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADV,
    ST_M1A,
    ST_M1B,
    ST_M1C,
    ST_M1D,
    ST_M2A,
    ST_M2B,
    ST_M2C,
    ST_M2D,
    ST_TMAG,
    ST_OFF0,
    ST_OFF1,
    ST_OFF2,
    ST_SUM
  } state_t;

  typedef enum logic [2:0] {
    MUL_MIX_LL,
    MUL_MIX_LH,
    MUL_MIX_HL,
    MUL_OFF_LO,
    MUL_OFF_HI
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI,
    ACC_INIT
  } acc_op_t;

  typedef enum logic [1:0] {
    Z_HOLD,
    Z_ADV,
    Z_MIX
  } z_op_t;

  typedef struct packed {
    logic     take;
    mul_sel_t mul_sel;
    logic     mix_b;
    acc_op_t  acc_op;
    z_op_t    z_op;
    logic     draw_push;
    logic     mag_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic dither_en;
  } status_t;

endpackage

`default_nettype wire

### rtl/tpdf_if.sv
// ----------------------------------------------------------------------------
// TPDF dither channels
// Valid/ready channels for input samples and dithered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpdf_in_if #(
  parameter int SAMPLE_WIDTH = tpdf_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface tpdf_out_if #(
  parameter int SAMPLE_WIDTH = tpdf_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           last_out;

  modport source (output valid, output sample_out, output last_out, input ready);
  modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

`default_nettype wire

### rtl/tpdf_ctrl.sv
// ----------------------------------------------------------------------------
// TPDF dither controller
// Sequences the generator rounds, offset product and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire tpdf_pkg::status_t status,
  output tpdf_pkg::cmd_t         cmd
);
  import tpdf_pkg::*;

  state_t state;
  state_t state_next;
  logic   second;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      second <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        second <= 1'b0;
      end else if (state == ST_M2D) begin
        second <= ~second;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.dither_en ? ST_ADV : ST_SUM;
        end
      end
      ST_ADV:  state_next = ST_M1A;
      ST_M1A:  state_next = ST_M1B;
      ST_M1B:  state_next = ST_M1C;
      ST_M1C:  state_next = ST_M1D;
      ST_M1D:  state_next = ST_M2A;
      ST_M2A:  state_next = ST_M2B;
      ST_M2B:  state_next = ST_M2C;
      ST_M2C:  state_next = ST_M2D;
      ST_M2D:  state_next = second ? ST_TMAG : ST_ADV;
      ST_TMAG: state_next = ST_OFF0;
      ST_OFF0: state_next = ST_OFF1;
      ST_OFF1: state_next = ST_OFF2;
      ST_OFF2: state_next = ST_SUM;
      ST_SUM: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_MIX_LL;
    cmd.acc_op    = ACC_HOLD;
    cmd.z_op      = Z_HOLD;
    case (state)
      ST_IDLE: cmd.take = 1'b1;
      ST_ADV:  cmd.z_op = Z_ADV;
      ST_M1A:  cmd.mul_sel = MUL_MIX_LL;
      ST_M1B: begin
        cmd.mul_sel = MUL_MIX_LH;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_M1C: begin
        cmd.mul_sel = MUL_MIX_HL;
        cmd.acc_op  = ACC_ADD_HI;
      end
      ST_M1D: begin
        cmd.acc_op = ACC_ADD_HI;
        cmd.z_op   = Z_MIX;
      end
      ST_M2A: begin
        cmd.mul_sel = MUL_MIX_LL;
        cmd.mix_b   = 1'b1;
      end
      ST_M2B: begin
        cmd.mul_sel = MUL_MIX_LH;
        cmd.mix_b   = 1'b1;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_M2C: begin
        cmd.mul_sel = MUL_MIX_HL;
        cmd.mix_b   = 1'b1;
        cmd.acc_op  = ACC_ADD_HI;
      end
      ST_M2D: begin
        cmd.acc_op    = ACC_ADD_HI;
        cmd.draw_push = 1'b1;
      end
      ST_TMAG: cmd.mag_load = 1'b1;
      ST_OFF0: begin
        cmd.mul_sel = MUL_OFF_LO;
        cmd.acc_op  = ACC_INIT;
      end
      ST_OFF1: begin
        cmd.mul_sel = MUL_OFF_HI;
        cmd.acc_op  = ACC_ADD;
      end
      ST_OFF2: cmd.acc_op = ACC_ADD_HI;
      ST_SUM:  cmd.out_load = status.out_free;
      default: cmd.take = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/tpdf_dp.sv
// ----------------------------------------------------------------------------
// TPDF dither datapath
// Generator state, shared 32x32 multiplier, accumulator, offset and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdf_dp #(
  parameter int SAMPLE_WIDTH = tpdf_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [tpdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tpdf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire tpdf_pkg::cmd_t                      cmd,
  output tpdf_pkg::status_t                        status,
  input  wire logic                                in_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  input  wire logic                                last_in,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]           sample_out,
  output logic                                     last_out
);
  import tpdf_pkg::*;

  localparam int SHIFT = 101 - SAMPLE_WIDTH;
  localparam int SUM_W = ((SAMPLE_WIDTH > OFF_W) ? SAMPLE_WIDTH : OFF_W) + 2;
  localparam logic [ACC_W-1:0] ROUND = {{(ACC_W-1){1'b0}}, 1'b1} << (SHIFT - 1);
  localparam logic signed [SUM_W-1:0] MAXV =
    {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] MINV = ~MAXV;

  logic [DEPTH_W-1:0]             depth_mode;
  logic [63:0]                    gstate;
  logic [63:0]                    z;
  logic [2*MUL_W-1:0]             prod;
  logic [ACC_W-1:0]               acc;
  logic [DRAW_W-1:0]              draw_a;
  logic [DRAW_W-1:0]              draw_b;
  logic [MAG_W-1:0]               mag;
  logic                           neg;
  logic signed [SAMPLE_WIDTH-1:0] smp;
  logic                           lst;

  logic [63:0]              gen_next;
  logic [63:0]              kmul;
  logic [STEP_W-1:0]        step;
  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic [ACC_W-1:0]         prod_ext;
  logic [ACC_W-1:0]         acc_next;
  logic [63:0]              mix_lo;
  logic [63:0]              fin;
  logic [MAG_W:0]           tsum;
  logic [MAG_W-1:0]         mag_val;
  logic [ACC_W-1:0]         acc_shr;
  logic [SUM_W-1:0]         off_ext;
  logic signed [SUM_W-1:0]  off_s;
  logic signed [SUM_W-1:0]  x_ext;
  logic signed [SUM_W-1:0]  sum;
  logic [SAMPLE_WIDTH-1:0]  sat;
  logic                     dither_en;

  assign dither_en = (depth_mode == DEPTH_16) || (depth_mode == DEPTH_24);
  assign status.dither_en = dither_en;
  assign status.out_free  = ~out_valid | out_ready;

  assign gen_next = gstate + GOLDEN_INC;
  assign kmul     = cmd.mix_b ? MIX_MUL_B : MIX_MUL_A;
  assign step     = (depth_mode == DEPTH_16) ? STEP16 : STEP24;

  always_comb begin
    case (cmd.mul_sel)
      MUL_MIX_LL: begin
        mul_a = z[MUL_W-1:0];
        mul_b = kmul[MUL_W-1:0];
      end
      MUL_MIX_LH: begin
        mul_a = z[MUL_W-1:0];
        mul_b = kmul[2*MUL_W-1:MUL_W];
      end
      MUL_MIX_HL: begin
        mul_a = z[2*MUL_W-1:MUL_W];
        mul_b = kmul[MUL_W-1:0];
      end
      MUL_OFF_LO: begin
        mul_a = mag[MUL_W-1:0];
        mul_b = step[MUL_W-1:0];
      end
      MUL_OFF_HI: begin
        mul_a = {{(2*MUL_W-MAG_W){1'b0}}, mag[MAG_W-1:MUL_W]};
        mul_b = step[MUL_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = {{(ACC_W-2*MUL_W){1'b0}}, prod};

  always_comb begin
    case (cmd.acc_op)
      ACC_HOLD:   acc_next = acc;
      ACC_LOAD:   acc_next = prod_ext;
      ACC_ADD:    acc_next = acc + prod_ext;
      ACC_ADD_HI: acc_next = acc + (prod_ext << MUL_W);
      ACC_INIT: begin
        acc_next = ROUND + (step[STEP_W-1] ?
                            {{(ACC_W-MAG_W-MUL_W){1'b0}}, mag, {MUL_W{1'b0}}} :
                            {ACC_W{1'b0}});
      end
      default:    acc_next = acc;
    endcase
  end

  assign mix_lo = acc_next[63:0];
  assign fin    = mix_lo ^ (mix_lo >> MIX_SHIFT_2);

  assign tsum    = {2'b00, draw_a} + {2'b00, draw_b} - ({{MAG_W{1'b0}}, 1'b1} << DRAW_W);
  assign mag_val = tsum[MAG_W] ? (~tsum[MAG_W-1:0] + 1'b1) : tsum[MAG_W-1:0];

  assign acc_shr = acc >> SHIFT;
  assign off_ext = {{(SUM_W-OFF_W){1'b0}}, acc_shr[OFF_W-1:0]};
  assign off_s   = neg ? -$signed(off_ext) : $signed(off_ext);
  assign x_ext   = {{(SUM_W-SAMPLE_WIDTH){smp[SAMPLE_WIDTH-1]}}, smp};
  assign sum     = x_ext + off_s;

  always_comb begin
    if (sum > MAXV) begin
      sat = MAXV[SAMPLE_WIDTH-1:0];
    end else if (sum < MINV) begin
      sat = MINV[SAMPLE_WIDTH-1:0];
    end else begin
      sat = sum[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= DEPTH_OFF;
      gstate     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEPTH_MODE: depth_mode <= cfg_data[DEPTH_W-1:0];
        REG_SEED:       gstate     <= cfg_data;
        default:        depth_mode <= depth_mode;
      endcase
    end else if (cmd.z_op == Z_ADV) begin
      gstate <= gen_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    acc  <= acc_next;
    case (cmd.z_op)
      Z_ADV:   z <= gen_next ^ (gen_next >> MIX_SHIFT_0);
      Z_MIX:   z <= mix_lo ^ (mix_lo >> MIX_SHIFT_1);
      default: z <= z;
    endcase
    if (cmd.draw_push) begin
      draw_a <= draw_b;
      draw_b <= fin[63:64-DRAW_W];
    end
    if (cmd.mag_load) begin
      mag <= mag_val;
      neg <= tsum[MAG_W];
    end
    if (cmd.take && in_valid) begin
      smp <= sample_in;
      lst <= last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_out <= dither_en ? sat : smp;
      last_out   <= lst;
    end
  end

endmodule

`default_nettype wire

### rtl/tpdf_dither_splitmix64.sv
// ----------------------------------------------------------------------------
// TPDF dither with splitmix64 noise
// Adds triangular dither to fixed-point audio samples and saturates the sum.
// ----------------------------------------------------------------------------
// A dithered sample is accepted in ST_IDLE, runs ST_ADV and the M1 and M2
// mix rounds for each of two draws, then ST_TMAG, ST_OFF0 to ST_OFF2 and
// ST_SUM, where its result is registered at the output; the next sample is
// taken back in ST_IDLE. With depth_mode off (or the unused code) the block
// goes from acceptance straight to ST_SUM and the generator holds. One shared
// 32x32 multiplier works through twelve partial products for the two
// splitmix64 draws and two for the offset product, one per cycle. One sample
// is in work at a time; a finished result waits in the output register while
// the next sample is taken and computed, and the last step holds only if that
// register is still full. Write configuration only while the block is idle;
// a seed write reloads the generator at once.
`default_nettype none

module tpdf_dither_splitmix64 #(
  parameter int SAMPLE_WIDTH = tpdf_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tpdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpdf_pkg::CFG_DATA_W-1:0] cfg_data,
  tpdf_in_if.sink                              din,
  tpdf_out_if.source                           dout
);
  import tpdf_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign din.ready = cmd.take;

  tpdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .status   (status),
    .cmd      (cmd)
  );

  tpdf_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .in_valid   (din.valid),
    .sample_in  (din.sample_in),
    .last_in    (din.last_in),
    .out_ready  (dout.ready),
    .out_valid  (dout.valid),
    .sample_out (dout.sample_out),
    .last_out   (dout.last_out)
  );

endmodule

`default_nettype wire

### rtl/tpdf_checker.sv
// ----------------------------------------------------------------------------
// TPDF dither port checker
// Watches the channel ports of the dither block over time.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdf_checker #(
  parameter int SAMPLE_WIDTH = tpdf_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [SAMPLE_WIDTH-1:0] sample_out,
  input wire logic                    last_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(sample_out) && $stable(last_out))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind tpdf_dither_splitmix64 tpdf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .sample_out (dout.sample_out),
  .last_out   (dout.last_out)
);

`default_nettype wire

### tb/tb_tpdf_dither_splitmix64.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TPDF dither testbench
// Streams audio samples through the dither block under several depth and
// seed settings with random idling on both channels. Each accepted sample is
// scored against a splitmix64 noise predictor kept inside the bench, and each
// dithered result is checked in order.
// ----------------------------------------------------------------------------

module tb_tpdf_dither_splitmix64;

  localparam int                 SW           = 32;
  localparam logic [1:0]         DEPTH_UNUSED = 2'd3;
  localparam logic signed [63:0] NOISE_MID    = 64'sd1 <<< 53;
  localparam logic signed [63:0] SAMPLE_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] SAMPLE_MIN   = -64'sd2147483648;
  localparam int                 STALL_LIMIT  = 4000;
  localparam int                 TAIL_CYCLES  = 40;
  localparam int                 RANDOM_ITEMS = 1100;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 last;
  } dither_item_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_wr_en;
  logic [tpdf_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [tpdf_pkg::CFG_DATA_W-1:0]    cfg_data;

  tpdf_in_if  #(.SAMPLE_WIDTH(SW)) din_if ();
  tpdf_out_if #(.SAMPLE_WIDTH(SW)) dout_if ();

  tpdf_dither_splitmix64 #(.SAMPLE_WIDTH(SW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_if),
    .dout      (dout_if)
  );

  dither_item_t sample_queue[$];
  dither_item_t expected_out[$];

  logic [1:0]  depth_cfg;
  logic [63:0] gen_state;
  logic        offered;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatches;
  int          samples_sent;
  int          results_checked;
  int          cfg_writes;
  int          idle_cycles;
  int          mode_count[4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [52:0] noise_draw();
    logic [63:0] z;
    gen_state = gen_state + tpdf_pkg::GOLDEN_INC;
    z = gen_state;
    z = (z ^ (z >> tpdf_pkg::MIX_SHIFT_0)) * tpdf_pkg::MIX_MUL_A;
    z = (z ^ (z >> tpdf_pkg::MIX_SHIFT_1)) * tpdf_pkg::MIX_MUL_B;
    z = z ^ (z >> tpdf_pkg::MIX_SHIFT_2);
    return z[63:11];
  endfunction

  function automatic logic [63:0] depth_step(input logic [1:0] mode);
    logic [63:0] d;
    d = (mode == tpdf_pkg::DEPTH_16) ? ((64'd1 << 15) - 1) : ((64'd1 << 23) - 1);
    return ((64'd1 << 47) + (d >> 1)) / d;
  endfunction

  function automatic logic signed [SW-1:0] dither_sample(input logic signed [SW-1:0] x);
    logic [63:0]        a_w;
    logic [63:0]        b_w;
    logic [63:0]        mag;
    logic [63:0]        r;
    logic [127:0]       prod;
    logic signed [63:0] t;
    logic signed [63:0] off;
    logic signed [63:0] wide;
    if (depth_cfg != tpdf_pkg::DEPTH_16 && depth_cfg != tpdf_pkg::DEPTH_24) return x;
    a_w  = {11'd0, noise_draw()};
    b_w  = {11'd0, noise_draw()};
    t    = $signed(a_w + b_w) - NOISE_MID;
    mag  = t[63] ? -t : t;
    prod = 128'(mag) * 128'(depth_step(depth_cfg)) + (128'd1 << 68);
    r    = 64'(prod >> 69);
    off  = t[63] ? -$signed(r) : $signed(r);
    wide = x;
    wide = wide + off;
    if (wide > SAMPLE_MAX) wide = SAMPLE_MAX;
    if (wide < SAMPLE_MIN) wide = SAMPLE_MIN;
    return wide[SW-1:0];
  endfunction

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // driver: hold an offered item until it is taken
  always @(negedge clk) begin
    if (rst) begin
      din_if.valid <= 1'b0;
    end else if (!offered) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        din_if.valid     <= 1'b1;
        din_if.sample_in <= sample_queue[0].sample;
        din_if.last_in   <= sample_queue[0].last;
        offered          <= 1'b1;
      end else begin
        din_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    dither_item_t item;
    if (!rst && din_if.valid && din_if.ready) begin
      mode_count[depth_cfg]++;
      item.sample = dither_sample(din_if.sample_in);
      item.last   = din_if.last_in;
      expected_out.push_back(item);
      void'(sample_queue.pop_front());
      offered <= 1'b0;
      samples_sent++;
    end
  end

  always @(negedge clk) begin
    dout_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    dither_item_t want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      results_checked++;
      if (expected_out.size() == 0) begin
        note_error($sformatf("result %0d / last %0b with no sample pending",
                             dout_if.sample_out, dout_if.last_out));
      end else begin
        want = expected_out.pop_front();
        if (dout_if.sample_out !== want.sample || dout_if.last_out !== want.last)
          note_error($sformatf("sample exp %0d got %0d, last exp %0b got %0b",
                               want.sample, dout_if.sample_out, want.last,
                               dout_if.last_out));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("tb_tpdf_dither_splitmix64: done, errors");
        $finish;
      end
    end
  end

  task automatic push_item(input logic signed [SW-1:0] sample, input logic last);
    dither_item_t item;
    item.sample = sample;
    item.last   = last;
    sample_queue.push_back(item);
  endtask

  task automatic write_reg(input logic [tpdf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    if (idx == tpdf_pkg::REG_DEPTH_MODE) depth_cfg = data[1:0];
    else gen_state = data;
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || expected_out.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] random_sample();
    case ($urandom_range(9))
      4:       return SAMPLE_MAX[SW-1:0] - SW'($urandom_range(131071));
      5:       return SAMPLE_MIN[SW-1:0] + SW'($urandom_range(131071));
      6:       return SW'($urandom_range(2000)) - SW'(1000);
      7:       return SAMPLE_MAX[SW-1:0];
      8:       return SAMPLE_MIN[SW-1:0];
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int         total;
    int         n;
    logic [1:0] mode;
    logic [63:0] word;
    din_if.valid     = 1'b0;
    din_if.sample_in = '0;
    din_if.last_in   = 1'b0;
    dout_if.ready    = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    offered          = 1'b0;
    depth_cfg        = tpdf_pkg::DEPTH_OFF;
    gen_state        = '0;
    send_idle_pct    = 34;
    recv_idle_pct    = 59;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // dither off and the unused code pass samples through
    push_item(SAMPLE_MAX[SW-1:0], 1'b0);
    push_item(SAMPLE_MIN[SW-1:0], 1'b1);
    push_item('0, 1'b0);
    push_item(-1, 1'b1);
    wait_drained();
    write_reg(tpdf_pkg::REG_DEPTH_MODE, {62'd0, DEPTH_UNUSED});
    push_item(32'sh1234_5678, 1'b0);
    push_item(-32'sh0765_4321, 1'b1);
    wait_drained();
    // sixteen-bit step from seed zero, saturation at both ends
    write_reg(tpdf_pkg::REG_DEPTH_MODE, {62'd0, tpdf_pkg::DEPTH_16});
    push_item(SAMPLE_MAX[SW-1:0], 1'b0);
    push_item(SAMPLE_MIN[SW-1:0], 1'b0);
    push_item(SAMPLE_MAX[SW-1:0] - 1, 1'b0);
    push_item(SAMPLE_MIN[SW-1:0] + 1, 1'b1);
    push_item('0, 1'b0);
    push_item(1, 1'b0);
    push_item(-1, 1'b1);
    wait_drained();
    // twenty-four-bit step, all-ones seed
    write_reg(tpdf_pkg::REG_SEED, '1);
    write_reg(tpdf_pkg::REG_DEPTH_MODE, {62'h3FFF_FFFF_FFFF_FFFF, tpdf_pkg::DEPTH_24});
    push_item(SAMPLE_MAX[SW-1:0], 1'b1);
    push_item(SAMPLE_MIN[SW-1:0], 1'b0);
    push_item(SAMPLE_MAX[SW-1:0] - 5, 1'b0);
    push_item(SAMPLE_MIN[SW-1:0] + 5, 1'b1);
    push_item('0, 1'b0);
    wait_drained();
    // reload the generator mid-stream
    write_reg(tpdf_pkg::REG_SEED, 64'h0123_4567_89AB_CDEF);
    write_reg(tpdf_pkg::REG_DEPTH_MODE, {62'd0, tpdf_pkg::DEPTH_16});
    push_item(32'sh4000_0000, 1'b0);
    push_item(-32'sh4000_0000, 1'b0);
    push_item(32'sh0000_ffff, 1'b1);

    total = 0;
    while (total < RANDOM_ITEMS) begin
      wait_drained();
      if (total < RANDOM_ITEMS / 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 59;
      end else if (total < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0:       word = '0;
          1:       word = '1;
          default: word = {$urandom, $urandom};
        endcase
        write_reg(tpdf_pkg::REG_SEED, word);
      end
      case ($urandom_range(9))
        0:       mode = tpdf_pkg::DEPTH_OFF;
        1:       mode = DEPTH_UNUSED;
        2, 3, 4, 5: mode = tpdf_pkg::DEPTH_16;
        default: mode = tpdf_pkg::DEPTH_24;
      endcase
      word = {$urandom, $urandom};
      write_reg(tpdf_pkg::REG_DEPTH_MODE, {word[63:2], mode});
      n = $urandom_range(80, 20);
      repeat (n) push_item(random_sample(), $urandom_range(7) == 0);
      total += n;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_out.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_out.size()));

    $display("%0d samples sent, %0d results checked, %0d register writes",
             samples_sent, results_checked, cfg_writes);
    $display("samples per depth: off %0d, 16-bit %0d, 24-bit %0d, unused code %0d",
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    if (mismatches == 0) begin
      $display("tb_tpdf_dither_splitmix64: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_tpdf_dither_splitmix64: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/tpdf_pkg.sv
rtl/tpdf_if.sv
rtl/tpdf_ctrl.sv
rtl/tpdf_dp.sv
rtl/tpdf_dither_splitmix64.sv
rtl/tpdf_checker.sv
tb/tb_tpdf_dither_splitmix64.sv
